[sv/pc_block_hot_histogram_unit_assert.svh]
// Assertion macros for the hot block histogram. Each checks an implication on clk,
// and is disabled while rst_n is low.
`ifndef PC_BLOCK_HOT_HISTOGRAM_UNIT_ASSERT_SVH
`define PC_BLOCK_HOT_HISTOGRAM_UNIT_ASSERT_SVH
`ifndef SYNTH
`define PCHH_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("pchh check failed");
`define PCHH_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("pchh check failed");
`else
`define PCHH_ASSERT_IMP(label, a, b)
`define PCHH_ASSERT_NXT(label, a, b)
`endif
`endif

[sv/pchh_pkg.sv]
`default_nettype none
package pchh_pkg;
  localparam int TABLE_BITS_DEF = 12;
  localparam int MAX_PROBES_DEF = 8;
  localparam int MAX_TOP_DEF    = 63;
  localparam int KEY_W          = 27;
  localparam int CNT_W          = 32;
  localparam int BLOCK_SHIFT    = 6;
  localparam logic [31:0] HASH_MULT = 32'd2654435761;

  // One table slot: block key (zero means empty) and its sample count.
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_DUMP   = 1'b1;
  localparam logic KIND_HDR   = 1'b0;
  localparam logic KIND_ENTRY = 1'b1;
endpackage
`default_nettype wire

[sv/pchh_ram.sv]
`default_nettype none
// Slot table: one write port, one read port, registered read data.
module pchh_ram #(
  parameter int ADDR_BITS = pchh_pkg::TABLE_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire pchh_pkg::entry_t     wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output pchh_pkg::entry_t          rdata
);
  pchh_pkg::entry_t mem [2**ADDR_BITS];
  pchh_pkg::entry_t rdata_r;

  // Write and read are both taken at the clock edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule
`default_nettype wire

[sv/pc_block_hot_histogram_unit.sv]
// Hot code block histogram.
// Input channel (in_valid/in_ready): a record beat carries a pc and mode bit and
// counts one sample for its 64-byte block; a dump beat asks for a ranked report.
// Output channel (out_valid/out_ready): a dump yields a header beat with the total
// and dropped counts, then up to top_n entries by falling count, lowest slot first
// on ties; out_last marks the final beat of a dump. Records yield nothing.
// A record hashes its key, then reads and checks one slot per probe, up to
// MAX_PROBES probes; the probes share the single read port of the slot memory.
// Each reported entry costs one full table scan, plus one more scan to find the
// end when fewer than top_n entries exist; then a clearing pass empties the
// table and both counters.
// After reset the same clearing pass runs with in_ready low. A stalled receiver
// holds the output beat and the dump simply waits.
// One beat is handled at a time; in_ready is high only while the block is idle.
`default_nettype none
`include "pc_block_hot_histogram_unit_assert.svh"
module pc_block_hot_histogram_unit #(
  parameter int TABLE_BITS = pchh_pkg::TABLE_BITS_DEF,
  parameter int MAX_PROBES = pchh_pkg::MAX_PROBES_DEF,
  parameter int MAX_TOP    = pchh_pkg::MAX_TOP_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_pc,
  input  wire logic        in_is_arm,
  input  wire logic [5:0]  in_top_n,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [31:0]      out_block_address,
  output logic             out_block_is_arm,
  output logic [31:0]      out_sample_count,
  output logic [31:0]      out_total_samples,
  output logic [31:0]      out_dropped_samples,
  output logic             out_last
);
  localparam int TB = TABLE_BITS;
  localparam int PW = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int KW = pchh_pkg::KEY_W;
  localparam int CW = pchh_pkg::CNT_W;
  localparam logic [5:0]    TOP_LIM  = 6'(MAX_TOP);
  localparam logic [PW-1:0] PROBE_LAST = PW'(MAX_PROBES - 1);

  typedef enum logic [3:0] {
    ST_SWEEP, ST_IDLE, ST_HASH, ST_PRD, ST_PCHK,
    ST_NEXT, ST_SCAN, ST_DECIDE, ST_OUT
  } state_t;

  state_t          state_r;
  logic [KW-1:0]   key_r;
  logic [TB-1:0]   h_r;
  logic [PW-1:0]   probe_r;
  logic [CW-1:0]   total_r;
  logic [CW-1:0]   dropped_r;
  logic [TB-1:0]   sweep_idx_r;
  logic [TB:0]     scan_idx_r;
  logic            cmp_valid_r;
  logic [TB-1:0]   cmp_idx_r;
  logic [CW-1:0]   best_cnt_r;
  logic [KW-1:0]   best_key_r;
  logic [TB-1:0]   best_idx_r;
  logic [5:0]      top_r;
  logic [5:0]      rank_r;
  logic            pend_kind_r;
  logic [KW-1:0]   pend_key_r;
  logic [CW-1:0]   pend_cnt_r;
  logic            final_r;
  logic            out_valid_r;
  logic            out_kind_r;
  logic [31:0]     out_addr_r;
  logic            out_arm_r;
  logic [CW-1:0]   out_cnt_r;
  logic [CW-1:0]   out_tot_r;
  logic [CW-1:0]   out_drp_r;
  logic            out_last_r;

  logic             mem_we;
  logic [TB-1:0]    mem_waddr;
  pchh_pkg::entry_t mem_wdata;
  logic [TB-1:0]    mem_raddr;
  pchh_pkg::entry_t mem_rdata;
  logic [31:0]      prod;
  logic [TB-1:0]    slot;
  logic             hit;
  logic             empty;
  logic             better;
  logic [5:0]       top_in;

  pchh_ram #(.ADDR_BITS(TB)) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Hash, probe slot and slot tests.
  assign prod   = {5'd0, key_r} * pchh_pkg::HASH_MULT;
  assign slot   = h_r + TB'(probe_r);
  assign hit    = (mem_rdata.key == key_r);
  assign empty  = (mem_rdata.key == '0);
  assign better = (mem_rdata.key != '0) && (mem_rdata.count > best_cnt_r);
  assign top_in = (in_top_n > TOP_LIM) ? TOP_LIM : in_top_n;

  // Memory port control.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = slot;
    mem_wdata = '0;
    mem_raddr = slot;
    case (state_r)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_idx_r;
      end
      ST_PCHK: begin
        mem_we          = hit || empty;
        mem_wdata.key   = key_r;
        mem_wdata.count = hit ? (mem_rdata.count + 1'b1) : CW'(1);
      end
      ST_SCAN: begin
        mem_raddr = scan_idx_r[TB-1:0];
      end
      ST_DECIDE: begin
        mem_we        = (best_cnt_r != '0);
        mem_waddr     = best_idx_r;
        mem_wdata.key = best_key_r;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Control sequence and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_idx_r <= '0;
      total_r     <= '0;
      dropped_r   <= '0;
      out_valid_r <= 1'b0;
      cmp_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_SWEEP: begin
          sweep_idx_r <= sweep_idx_r + 1'b1;
          if (sweep_idx_r == '1) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            if (in_req_type == pchh_pkg::REQ_RECORD) begin
              key_r   <= {in_pc[31:pchh_pkg::BLOCK_SHIFT], in_is_arm};
              state_r <= ST_HASH;
            end else begin
              top_r       <= top_in;
              rank_r      <= '0;
              pend_kind_r <= pchh_pkg::KIND_HDR;
              pend_key_r  <= '0;
              pend_cnt_r  <= '0;
              state_r     <= ST_NEXT;
            end
          end
        end
        ST_HASH: begin
          h_r     <= prod[31 -: TB];
          probe_r <= '0;
          state_r <= ST_PRD;
        end
        ST_PRD: begin
          state_r <= ST_PCHK;
        end
        ST_PCHK: begin
          if (hit || empty) begin
            total_r <= total_r + 1'b1;
            state_r <= ST_IDLE;
          end else if (probe_r == PROBE_LAST) begin
            dropped_r <= dropped_r + 1'b1;
            state_r   <= ST_IDLE;
          end else begin
            probe_r <= probe_r + 1'b1;
            state_r <= ST_PRD;
          end
        end
        ST_NEXT: begin
          if (rank_r == top_r) begin
            final_r     <= 1'b1;
            out_last_r  <= 1'b1;
            out_valid_r <= 1'b1;
            state_r     <= ST_OUT;
          end else begin
            scan_idx_r  <= '0;
            cmp_valid_r <= 1'b0;
            best_cnt_r  <= '0;
            state_r     <= ST_SCAN;
          end
          out_kind_r <= pend_kind_r;
          out_addr_r <= {pend_key_r[KW-1:1], pchh_pkg::BLOCK_SHIFT'(0)};
          out_arm_r  <= pend_key_r[0];
          out_cnt_r  <= pend_cnt_r;
          out_tot_r  <= (pend_kind_r == pchh_pkg::KIND_HDR) ? total_r : '0;
          out_drp_r  <= (pend_kind_r == pchh_pkg::KIND_HDR) ? dropped_r : '0;
        end
        ST_SCAN: begin
          // Issue one read a cycle and compare the data from the cycle before.
          cmp_valid_r <= !scan_idx_r[TB];
          cmp_idx_r   <= scan_idx_r[TB-1:0];
          if (!scan_idx_r[TB]) begin
            scan_idx_r <= scan_idx_r + 1'b1;
          end
          if (cmp_valid_r && better) begin
            best_cnt_r <= mem_rdata.count;
            best_key_r <= mem_rdata.key;
            best_idx_r <= cmp_idx_r;
          end
          if (scan_idx_r[TB] && !cmp_valid_r) begin
            state_r <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          // The held beat goes out; a found entry becomes the next held beat.
          final_r     <= (best_cnt_r == '0);
          out_last_r  <= (best_cnt_r == '0);
          out_valid_r <= 1'b1;
          if (best_cnt_r != '0) begin
            pend_kind_r <= pchh_pkg::KIND_ENTRY;
            pend_key_r  <= best_key_r;
            pend_cnt_r  <= best_cnt_r;
            rank_r      <= rank_r + 1'b1;
          end
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (final_r) begin
              total_r     <= '0;
              dropped_r   <= '0;
              sweep_idx_r <= '0;
              state_r     <= ST_SWEEP;
            end else begin
              out_last_r <= 1'b0;
              state_r    <= ST_NEXT;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
      if (state_r == ST_NEXT && rank_r != top_r) begin
        out_last_r <= 1'b0;
      end
    end
  end

  assign in_ready            = (state_r == ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_kind            = out_kind_r;
  assign out_block_address   = out_addr_r;
  assign out_block_is_arm    = out_arm_r;
  assign out_sample_count    = out_cnt_r;
  assign out_total_samples   = out_tot_r;
  assign out_dropped_samples = out_drp_r;
  assign out_last            = out_last_r;

  `PCHH_ASSERT_IMP(a_idle_no_beat, in_ready, !out_valid_r)
  `PCHH_ASSERT_IMP(a_scan_no_write, state_r == ST_SCAN, !mem_we)
  `PCHH_ASSERT_NXT(a_last_sweeps, out_valid && out_ready && out_last, state_r == ST_SWEEP)
  `PCHH_ASSERT_NXT(a_record_hash, in_valid && in_ready && !in_req_type, state_r == ST_HASH)
endmodule
`default_nettype wire

[verif/tb_pc_block_hot_histogram_unit.sv]
`default_nettype none
module tb_pc_block_hot_histogram_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_SIZE   = 1 << pchh_pkg::TABLE_BITS_DEF;
  localparam int CYCLE_CAP  = 40000000;
  localparam int DRAIN_WAIT = TBL_SIZE + 200;
  localparam int RAND_ITEMS = 330;

  // One beat on the result channel.
  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic        arm;
    logic [31:0] cnt;
    logic [31:0] tot;
    logic [31:0] drp;
    logic        last;
  } hist_beat_t;

  // Histogram predictor plus the queue of dump beats still owed by the block.
  class hist_scoreboard;
    logic [pchh_pkg::KEY_W-1:0] key_tbl[TBL_SIZE];
    logic [pchh_pkg::CNT_W-1:0] cnt_tbl[TBL_SIZE];
    logic [31:0]      total_cnt;
    logic [31:0]      drop_cnt;
    hist_beat_t       owed_beats[$];
    int               errors;

    function new();
      clear_table();
      errors = 0;
    endfunction

    function void clear_table();
      for (int i = 0; i < TBL_SIZE; i++) begin
        key_tbl[i] = '0;
        cnt_tbl[i] = '0;
      end
      total_cnt = '0;
      drop_cnt  = '0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // Count one sample by linear probing from the hashed slot.
    function void count_sample(logic [31:0] pc, logic arm);
      logic [pchh_pkg::KEY_W-1:0] key;
      logic [31:0]      prod;
      int               slot;
      key  = {pc[31:pchh_pkg::BLOCK_SHIFT], arm};
      prod = 32'(key) * pchh_pkg::HASH_MULT;
      for (int p = 0; p < pchh_pkg::MAX_PROBES_DEF; p++) begin
        slot = (int'(prod >> (32 - pchh_pkg::TABLE_BITS_DEF)) + p) % TBL_SIZE;
        if (key_tbl[slot] == key) begin
          cnt_tbl[slot]++;
          total_cnt++;
          return;
        end
        if (key_tbl[slot] == '0) begin
          key_tbl[slot] = key;
          cnt_tbl[slot] = 32'd1;
          total_cnt++;
          return;
        end
      end
      drop_cnt++;
    endfunction

    // Header, then ranked entries by falling count; the table is wiped after.
    function void rank_and_clear(logic [5:0] top_n);
      hist_beat_t b;
      int         lim;
      int         best_idx;
      logic [31:0] best;
      lim = (top_n > pchh_pkg::MAX_TOP_DEF) ? pchh_pkg::MAX_TOP_DEF : int'(top_n);
      b = '{pchh_pkg::KIND_HDR, 32'd0, 1'b0, 32'd0, total_cnt, drop_cnt, 1'b0};
      owed_beats.push_back(b);
      for (int r = 0; r < lim; r++) begin
        best = 0;
        best_idx = 0;
        for (int i = 0; i < TBL_SIZE; i++) begin
          if (key_tbl[i] != '0 && cnt_tbl[i] > best) begin
            best = cnt_tbl[i];
            best_idx = i;
          end
        end
        if (best == 0) break;
        b = '{pchh_pkg::KIND_ENTRY, {key_tbl[best_idx][pchh_pkg::KEY_W-1:1], 6'd0},
              key_tbl[best_idx][0], best, 32'd0, 32'd0, 1'b0};
        owed_beats.push_back(b);
        cnt_tbl[best_idx] = '0;
      end
      owed_beats[owed_beats.size()-1].last = 1'b1;
      clear_table();
    endfunction

    function void note_input(logic req, logic [31:0] pc, logic arm, logic [5:0] top_n);
      if (req == pchh_pkg::REQ_RECORD) count_sample(pc, arm);
      else rank_and_clear(top_n);
    endfunction

    task check_result(hist_beat_t got);
      hist_beat_t want;
      if (owed_beats.size() == 0) begin
        report($sformatf("unexpected beat %p", got));
        return;
      end
      want = owed_beats.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind got %0d want %0d", got.kind, want.kind));
      if (got.addr !== want.addr)
        report($sformatf("block_address got %h want %h", got.addr, want.addr));
      if (got.arm !== want.arm)
        report($sformatf("block_is_arm got %0d want %0d", got.arm, want.arm));
      if (got.cnt !== want.cnt)
        report($sformatf("sample_count got %0d want %0d", got.cnt, want.cnt));
      if (got.tot !== want.tot)
        report($sformatf("total_samples got %0d want %0d", got.tot, want.tot));
      if (got.drp !== want.drp)
        report($sformatf("dropped_samples got %0d want %0d", got.drp, want.drp));
      if (got.last !== want.last)
        report($sformatf("last got %0d want %0d", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_req_type;
  logic [31:0] in_pc;
  logic        in_is_arm;
  logic [5:0]  in_top_n;
  logic        out_valid;
  logic        out_ready;
  logic        out_kind;
  logic [31:0] out_block_address;
  logic        out_block_is_arm;
  logic [31:0] out_sample_count;
  logic [31:0] out_total_samples;
  logic [31:0] out_dropped_samples;
  logic        out_last;

  hist_scoreboard sb;
  int  cycle_cnt;
  bit  steady_phase;

  pc_block_hot_histogram_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_req_type(in_req_type), .in_pc(in_pc), .in_is_arm(in_is_arm), .in_top_n(in_top_n),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_kind(out_kind), .out_block_address(out_block_address),
    .out_block_is_arm(out_block_is_arm), .out_sample_count(out_sample_count),
    .out_total_samples(out_total_samples), .out_dropped_samples(out_dropped_samples),
    .out_last(out_last)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("pc_block_hot_histogram_unit regression: fail");
      $finish;
    end
  end

  // Send one beat after a random gap (none in the steady phase); valid stays up when there is no gap.
  task send_beat(logic req, logic [31:0] pc, logic arm, logic [5:0] top_n);
    int gap;
    gap = steady_phase ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= req;
    in_pc       <= pc;
    in_is_arm   <= arm;
    in_top_n    <= top_n;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(req, pc, arm, top_n);
  endtask

  task record(logic [31:0] pc, logic arm);
    send_beat(pchh_pkg::REQ_RECORD, pc, arm, 6'($urandom_range(0, 63)));
  endtask

  task dump(logic [5:0] top_n);
    send_beat(pchh_pkg::REQ_DUMP, $urandom, 1'($urandom_range(0, 1)), top_n);
  endtask

  task wait_drained();
    in_valid <= 1'b0;
    while (sb.owed_beats.size() != 0) @(posedge clk);
  endtask

  // Result side: random stall before each beat outside the steady phase, then check it.
  initial begin
    int stall;
    hist_beat_t got;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady_phase ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      got = '{out_kind, out_block_address, out_block_is_arm, out_sample_count,
              out_total_samples, out_dropped_samples, out_last};
      sb.check_result(got);
    end
  end

  // Stimulus: directed corners, then hot-block random traffic.
  initial begin
    logic [pchh_pkg::KEY_W-1:0] k;
    logic [pchh_pkg::KEY_W-1:0] clash_keys[$];
    logic [31:0]      prod;
    logic [31:0]      h0;
    logic [31:0]      hot_pc[12];
    logic             hot_arm[12];
    int               sel;
    sb = new();
    cycle_cnt    = 0;
    steady_phase = 1'b0;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req_type  = pchh_pkg::REQ_RECORD;
    in_pc        = '0;
    in_is_arm    = 1'b0;
    in_top_n     = '0;

    // Nine keys sharing one home slot overflow the probe window.
    prod = 32'd2 * pchh_pkg::HASH_MULT;
    h0 = prod >> (32 - pchh_pkg::TABLE_BITS_DEF);
    k = 27'd2;
    while (clash_keys.size() < pchh_pkg::MAX_PROBES_DEF + 1) begin
      prod = 32'(k) * pchh_pkg::HASH_MULT;
      if ((prod >> (32 - pchh_pkg::TABLE_BITS_DEF)) == h0) clash_keys.push_back(k);
      k++;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Key zero, address extremes, repeats and a probe overflow.
    record(32'h0000_003F, 1'b0);
    record(32'h0000_0000, 1'b1);
    record(32'hFFFF_FFFF, 1'b1);
    record(32'hFFFF_FFC0, 1'b0);
    repeat (3) record(32'h0000_1234, 1'b1);
    foreach (clash_keys[i])
      record({clash_keys[i][pchh_pkg::KEY_W-1:1], 6'($urandom)}, clash_keys[i][0]);
    dump(6'd5);
    record(32'hAAAA_AAAA, 1'b0);
    record(32'h5555_5555, 1'b1);
    dump(6'd0);
    record(32'h1000_0040, 1'b0);
    record(32'h1000_0040, 1'b0);
    record(32'h2000_0000, 1'b1);
    dump(6'd63);

    // The sender holds off once until the block has nothing owed.
    wait_drained();

    for (int i = 0; i < 12; i++) begin
      hot_pc[i]  = $urandom;
      hot_arm[i] = 1'($urandom_range(0, 1));
    end
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 40 == 0) steady_phase = ($urandom_range(0, 2) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        dump(($urandom_range(0, 7) == 0) ? 6'($urandom_range(0, 63))
                                         : 6'($urandom_range(0, 3)));
      end else if (sel < 60) begin
        sel = $urandom_range(0, ($urandom_range(0, 1) == 0) ? 2 : 11);
        record({hot_pc[sel][31:6], 6'($urandom)}, hot_arm[sel]);
      end else if (sel < 64) begin
        record(32'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
      end else begin
        record($urandom, 1'($urandom_range(0, 1)));
      end
    end
    dump(6'd4);

    // Drain, then allow the post-dump clearing pass to finish.
    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.errors == 0 && sb.owed_beats.size() == 0)
      $display("pc_block_hot_histogram_unit regression: pass");
    else
      $display("pc_block_hot_histogram_unit regression: fail");
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+sv
sv/pchh_pkg.sv
sv/pchh_ram.sv
sv/pc_block_hot_histogram_unit.sv
verif/tb_pc_block_hot_histogram_unit.sv
